// ===== hdl/histogram_equalizer_rgb_core_assert.svh =====
// Assertion macros shared by the histogram equaliser RTL.
`ifndef HISTOGRAM_EQUALIZER_RGB_CORE_ASSERT_SVH
`define HISTOGRAM_EQUALIZER_RGB_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/heq_pkg.sv =====
// Constants, codes and shared types of the histogram equaliser.
package heq_pkg;

  localparam int BINS            = 256;
  localparam int MAX_PIXELS_LOG2 = 24;

  localparam int BIN_W   = $clog2(BINS);
  localparam int CNT_W   = MAX_PIXELS_LOG2 + 1;
  localparam int CHAN_W  = 8;
  localparam int QUOT_W  = 8;
  localparam int DEN_W   = CNT_W + 1;
  localparam int FIN_NUM_W = MAX_PIXELS_LOG2 + $clog2(2 * BINS);
  localparam int NUM_W   = (FIN_NUM_W > 2 * CHAN_W) ? FIN_NUM_W : 2 * CHAN_W;
  localparam int REM_W   = ((DEN_W + QUOT_W) > NUM_W) ? (DEN_W + QUOT_W) : NUM_W;
  localparam int STEP_W  = $clog2(QUOT_W + 1);

  // Scale applied to the running count: twice the top level, for round half up.
  localparam int FIN_SCALE = 2 * (BINS - 1);

  // Division of the channel sum by three through a reciprocal.
  localparam int SUM_W       = CHAN_W + 2;
  localparam int GRAY_PROD_W = 20;
  localparam int DIV3_RECIP  = 683;
  localparam int DIV3_SHIFT  = 11;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ACC    = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_MAP    = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_FIN_RD,
    ST_FIN_MUL,
    ST_FIN_GO,
    ST_FIN_DIV,
    ST_MAP_RD,
    ST_MAP_LVL,
    ST_MAP_MUL,
    ST_MAP_GO,
    ST_MAP_DIV,
    ST_MAP_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hdl/histogram_equalizer_rgb_core.sv =====
// Top level of the two-pass RGB histogram equaliser.
// After reset the block sweeps the histogram memory to zero, one bin a cycle, over all
// BINS (256) bins, and stalls its input meanwhile. A clear beat runs the same sweep; an
// accumulate beat is a read-modify-write of one bin in the histogram memory, or only the
// read once the pixel total is full. A finish beat walks every bin: one memory read, one
// multiply, one divider start, eight steps of the shared one-bit-per-cycle divider and a
// level write. A map beat reads the level table and then runs the shared divider once per
// channel, with a multiply, a divider start and the divide steps for each, and then waits
// for the output register to be free. One beat is worked on at a time; the result sits in
// an output register, so the next beat is taken while the result waits for the sink. A map
// beat before any finish returns undefined levels.
module histogram_equalizer_rgb_core import heq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [CHAN_W-1:0] red_in_i,
  input  logic [CHAN_W-1:0] green_in_i,
  input  logic [CHAN_W-1:0] blue_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAN_W-1:0] red_out_o,
  output logic [CHAN_W-1:0] green_out_o,
  output logic [CHAN_W-1:0] blue_out_o,
  output logic [CHAN_W-1:0] new_level_o
);

  `include "histogram_equalizer_rgb_core_assert.svh"

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);

  state_e state_q, state_d;

  logic [BIN_W-1:0]  idx_q, idx_d;
  logic [1:0]        ch_q, ch_d;
  logic [CNT_W-1:0]  cum_q, cum_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [NUM_W-1:0]  prod_q, prod_d;
  logic [CHAN_W-1:0] level_q, level_d;
  logic [CHAN_W-1:0] res_q [3];
  logic [CHAN_W-1:0] res_d [3];
  logic [CHAN_W-1:0] red_q, green_q, blue_q;
  logic              out_valid_q, out_valid_d;
  logic [CHAN_W-1:0] out_red_q, out_green_q, out_blue_q, out_level_q;
  logic              in_accept;
  logic              out_load;

  logic [SUM_W-1:0]       chan_sum;
  logic [GRAY_PROD_W-1:0] gray_prod;
  logic [CHAN_W-1:0]      gray;
  logic [BIN_W-1:0]       bin;
  logic [CHAN_W-1:0]      chan_sel;

  logic              bin_we;
  logic [BIN_W-1:0]  bin_waddr, bin_raddr;
  logic [CNT_W-1:0]  bin_wdata, bin_rdata;
  logic              lvl_we;
  logic [BIN_W-1:0]  lvl_waddr, lvl_raddr;
  logic [CHAN_W-1:0] lvl_wdata, lvl_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Gray level of the held pixel, clamped to the top bin for the memory index.
  assign chan_sum  = SUM_W'(red_q) + SUM_W'(green_q) + SUM_W'(blue_q);
  assign gray_prod = GRAY_PROD_W'(chan_sum) * GRAY_PROD_W'(DIV3_RECIP);
  assign gray      = gray_prod[DIV3_SHIFT+CHAN_W-1:DIV3_SHIFT];
  assign bin       = (32'(gray) > BINS - 1) ? LAST_BIN : BIN_W'(gray);

  always_comb begin
    case (ch_q)
      2'd0:    chan_sel = red_q;
      2'd1:    chan_sel = green_q;
      default: chan_sel = blue_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (idx_q == LAST_BIN) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_e'(mode_i))
            MODE_CLEAR:  state_d = ST_CLEAR;
            MODE_ACC:    state_d = ST_ACC_RD;
            MODE_FINISH: state_d = ST_FIN_RD;
            default:     state_d = ST_MAP_RD;
          endcase
        end
      end
      ST_ACC_RD:  state_d = total_q[CNT_W-1] ? ST_IDLE : ST_ACC_WR;
      ST_ACC_WR:  state_d = ST_IDLE;
      ST_FIN_RD:  state_d = ST_FIN_MUL;
      ST_FIN_MUL: state_d = ST_FIN_GO;
      ST_FIN_GO:  state_d = ST_FIN_DIV;
      ST_FIN_DIV: begin
        if (div_rsp.done) state_d = (idx_q == LAST_BIN) ? ST_IDLE : ST_FIN_RD;
      end
      ST_MAP_RD:  state_d = ST_MAP_LVL;
      ST_MAP_LVL: state_d = ST_MAP_MUL;
      ST_MAP_MUL: state_d = ST_MAP_GO;
      ST_MAP_GO:  state_d = ST_MAP_DIV;
      ST_MAP_DIV: begin
        if (div_rsp.done) state_d = (ch_q == 2'd2) ? ST_MAP_OUT : ST_MAP_MUL;
      end
      ST_MAP_OUT: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Memory controls, divider requests and datapath updates.
  always_comb begin
    idx_d       = idx_q;
    ch_d        = ch_q;
    cum_d       = cum_q;
    total_d     = total_q;
    prod_d      = prod_q;
    level_d     = level_q;
    res_d       = res_q;
    bin_we      = 1'b0;
    bin_waddr   = bin;
    bin_wdata   = bin_rdata + CNT_W'(1);
    bin_raddr   = bin;
    lvl_we      = 1'b0;
    lvl_waddr   = idx_q;
    lvl_wdata   = (total_q == '0) ? '0 : div_rsp.quot;
    lvl_raddr   = bin;
    div_req     = '0;
    out_load    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        bin_we    = 1'b1;
        bin_waddr = idx_q;
        bin_wdata = '0;
        idx_d     = idx_q + BIN_W'(1);
      end
      ST_IDLE: begin
        idx_d = '0;
        ch_d  = 2'd0;
        cum_d = '0;
        if (in_valid_i && (mode_e'(mode_i) == MODE_CLEAR)) total_d = '0;
      end
      ST_ACC_WR: begin
        bin_we  = 1'b1;
        total_d = total_q + CNT_W'(1);
      end
      ST_FIN_RD: begin
        bin_raddr = idx_q;
      end
      ST_FIN_MUL: begin
        // The level uses the count before this bin; the bin joins afterwards.
        prod_d = NUM_W'(cum_q) * NUM_W'(FIN_SCALE);
        cum_d  = cum_q + bin_rdata;
      end
      ST_FIN_GO: begin
        div_req.start = 1'b1;
        div_req.num   = prod_q + NUM_W'(total_q);
        div_req.den   = DEN_W'(total_q) << 1;
      end
      ST_FIN_DIV: begin
        if (div_rsp.done) begin
          lvl_we = 1'b1;
          idx_d  = idx_q + BIN_W'(1);
        end
      end
      ST_MAP_LVL: begin
        level_d = lvl_rdata;
      end
      ST_MAP_MUL: begin
        prod_d = NUM_W'(chan_sel) * NUM_W'(level_q);
      end
      ST_MAP_GO: begin
        div_req.start = 1'b1;
        div_req.num   = prod_q;
        div_req.den   = DEN_W'(gray);
      end
      ST_MAP_DIV: begin
        if (div_rsp.done) begin
          res_d[ch_q] = (gray == '0) ? '0 : div_rsp.quot;
          ch_d        = ch_q + 2'd1;
        end
      end
      ST_MAP_OUT: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      ch_q        <= 2'd0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      ch_q        <= ch_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cum_q   <= cum_d;
    prod_q  <= prod_d;
    level_q <= level_d;
    res_q   <= res_d;
    if (in_accept) begin
      red_q   <= red_in_i;
      green_q <= green_in_i;
      blue_q  <= blue_in_i;
    end
    if (out_load) begin
      out_red_q   <= res_q[0];
      out_green_q <= res_q[1];
      out_blue_q  <= res_q[2];
      out_level_q <= level_q;
    end
  end

  heq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BINS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wdata),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  heq_ram #(
    .WIDTH (CHAN_W),
    .DEPTH (BINS)
  ) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

  heq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_red_q;
  assign green_out_o = out_green_q;
  assign blue_out_o  = out_blue_q;
  assign new_level_o = out_level_q;

  `HEQ_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy,
                  "divider started while busy")
  `HEQ_ASSERT_IMP(a_div_done_state, div_rsp.done,
                  (state_q == ST_FIN_DIV) || (state_q == ST_MAP_DIV),
                  "divider result arrived outside a divide state")
  `HEQ_ASSERT_IMP(a_acc_not_full, state_q == ST_ACC_WR, !total_q[CNT_W-1],
                  "bin counted with the pixel total already full")
  `HEQ_ASSERT_NXT(a_out_hold, (state_q == ST_MAP_OUT) && out_valid_q && out_stall_i,
                  state_q == ST_MAP_OUT, "map result overwrote a waiting beat")

endmodule

// ===== hdl/heq_ram.sv =====
// Generic single-clock RAM with one write port and a registered read port.
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/heq_div.sv =====
// Shared restoring divider, one quotient bit per cycle, saturating quotient.
module heq_div import heq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              sat_q, sat_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [REM_W-1:0]  dsh_q, dsh_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [REM_W-1:0]  den_full;
  logic              fits;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    sat_d    = sat_q;
    step_d   = step_q;
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    quot_d   = quot_q;
    den_full = REM_W'(req_i.den) << QUOT_W;
    fits     = (rem_q >= dsh_q);
    if (req_i.start) begin
      // A quotient that needs more bits than the result has saturates.
      sat_d  = (REM_W'(req_i.num) >= den_full);
      rem_d  = REM_W'(req_i.num);
      dsh_d  = REM_W'(req_i.den) << (QUOT_W - 1);
      quot_d = '0;
      step_d = STEP_W'(QUOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? (rem_q - dsh_q) : rem_q;
      quot_d = {quot_q[QUOT_W-2:0], fits};
      dsh_d  = dsh_q >> 1;
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q  <= sat_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = sat_q ? '1 : quot_q;

endmodule

// ===== tb/histogram_equalizer_rgb_core_tb.sv =====
// Self-checking testbench for the RGB histogram equaliser core.
`timescale 1ns / 100ps

module histogram_equalizer_rgb_core_tb import heq_pkg::*; ();

  localparam int TOTAL_BEATS    = 500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] level;
  } equalized_pixel_t;

  // Predicts the equaliser and holds the mapped pixels still owed by the block.
  class equalizer_scoreboard;
    bit [CNT_W-1:0]    bin_count [BINS];
    bit [CHAN_W-1:0]   level_map [BINS];
    bit [CNT_W-1:0]    pixel_count;
    equalized_pixel_t  owed_pixels [$];
    int                failures;

    function new();
      foreach (bin_count[i]) bin_count[i] = '0;
      foreach (level_map[i]) level_map[i] = '0;
      pixel_count = '0;
      failures    = 0;
    endfunction

    function int unsigned grey_level(logic [23:0] rgb);
      return (int'(rgb[23:16]) + int'(rgb[15:8]) + int'(rgb[7:0])) / 3;
    endfunction

    function int unsigned level_bin(int unsigned grey);
      return (grey > BINS - 1) ? BINS - 1 : grey;
    endfunction

    function logic [CHAN_W-1:0] scaled_channel(logic [CHAN_W-1:0] c, logic [CHAN_W-1:0] lvl,
                                               int unsigned grey);
      int unsigned v;
      if (grey == 0) return '0;
      v = (int'(c) * int'(lvl)) / grey;
      return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    // Exclusive running count scaled to the top level, rounded half up.
    function void rebuild_levels();
      longint unsigned running;
      longint unsigned total;
      longint unsigned lvl;
      running = 0;
      total   = pixel_count;
      for (int i = 0; i < BINS; i++) begin
        lvl = 0;
        if (total != 0) lvl = (longint'(2 * (BINS - 1)) * running + total) / (2 * total);
        if (lvl > 255) lvl = 255;
        level_map[i] = lvl[7:0];
        running += bin_count[i];
      end
    endfunction

    function void note_beat(mode_e mode, logic [23:0] rgb);
      int unsigned grey;
      int unsigned idx;
      equalized_pixel_t px;
      grey = grey_level(rgb);
      idx  = level_bin(grey);
      case (mode)
        MODE_CLEAR: begin
          foreach (bin_count[i]) bin_count[i] = '0;
          pixel_count = '0;
        end
        MODE_ACC: begin
          if (pixel_count < (CNT_W'(1) << MAX_PIXELS_LOG2)) begin
            bin_count[idx]++;
            pixel_count++;
          end
        end
        MODE_FINISH: rebuild_levels();
        default: begin
          px.level = level_map[idx];
          px.red   = scaled_channel(rgb[23:16], px.level, grey);
          px.green = scaled_channel(rgb[15:8], px.level, grey);
          px.blue  = scaled_channel(rgb[7:0], px.level, grey);
          owed_pixels = {owed_pixels, px};
        end
      endcase
    endfunction

    function void check_result(equalized_pixel_t got);
      equalized_pixel_t want;
      if (owed_pixels.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected pixel: r=%0d g=%0d b=%0d level=%0d",
                   got.red, got.green, got.blue, got.level);
        return;
      end
      want = owed_pixels.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.level !== want.level) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("pixel mismatch: expected r=%0d g=%0d b=%0d level=%0d, got r=%0d g=%0d b=%0d level=%0d",
                   want.red, want.green, want.blue, want.level,
                   got.red, got.green, got.blue, got.level);
      end
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        mode_i;
  logic [CHAN_W-1:0] red_in_i;
  logic [CHAN_W-1:0] green_in_i;
  logic [CHAN_W-1:0] blue_in_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [CHAN_W-1:0] red_out_o;
  logic [CHAN_W-1:0] green_out_o;
  logic [CHAN_W-1:0] blue_out_o;
  logic [CHAN_W-1:0] new_level_o;

  equalizer_scoreboard sb;
  int beats_sent     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 20;
  int recv_stall_pct = 52;
  int pixel_centre   = 128;

  histogram_equalizer_rgb_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .new_level_o (new_level_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Scores every accepted beat on both channels and watches for a hung block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result({red_out_o, green_out_o, blue_out_o, new_level_o});
      if (in_valid_i && !in_stall_o)
        sb.note_beat(mode_e'(mode_i), {red_in_i, green_in_i, blue_in_i});
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(input mode_e mode, input logic [23:0] rgb);
    int phase;
    phase = beats_sent * 3 / TOTAL_BEATS;
    if (phase == 0) begin
      send_idle_pct  = 20;
      recv_stall_pct = 52;
    end else if (phase == 1) begin
      send_idle_pct  = 52;
      recv_stall_pct = 20;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    red_in_i   <= rgb[23:16];
    green_in_i <= rgb[15:8];
    blue_in_i  <= rgb[7:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // A mix of fully random, saturated, dark-with-one-bright and clustered pixels.
  function automatic logic [23:0] random_pixel();
    logic [7:0] c [3];
    int style;
    int v;
    style = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      if (style < 4) begin
        c[k] = 8'($urandom_range(0, 255));
      end else if (style < 5) begin
        c[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else if (style < 7) begin
        c[k] = ($urandom_range(0, 2) == k) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 7));
      end else begin
        v = pixel_centre + int'($urandom_range(0, 16)) - 8;
        c[k] = (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : v[7:0];
      end
    end
    return {c[0], c[1], c[2]};
  endfunction

  // A well-formed pass over one image, now and then without its finish beat.
  task automatic run_frame();
    int n_acc;
    int n_map;
    pixel_centre = $urandom_range(0, 255);
    n_acc = $urandom_range(1, 40);
    n_map = $urandom_range(4, 30);
    if ($urandom_range(0, 1)) send_beat(MODE_CLEAR, random_pixel());
    repeat (n_acc) send_beat(MODE_ACC, random_pixel());
    if ($urandom_range(0, 7) != 0) send_beat(MODE_FINISH, random_pixel());
    repeat (n_map) send_beat(MODE_MAP, random_pixel());
  endtask

  initial begin
    mode_e noise_mode;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_CLEAR;
    red_in_i    = '0;
    green_in_i  = '0;
    blue_in_i   = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme pixels, grey zero, saturation and an empty histogram.
    send_beat(MODE_CLEAR, 24'h000000);
    send_beat(MODE_ACC, 24'h000000);
    send_beat(MODE_ACC, 24'hFFFFFF);
    send_beat(MODE_ACC, 24'hFF0000);
    send_beat(MODE_ACC, 24'h00FF00);
    send_beat(MODE_ACC, 24'h0000FF);
    send_beat(MODE_ACC, 24'h010101);
    send_beat(MODE_ACC, 24'h804020);
    send_beat(MODE_ACC, 24'h555556);
    send_beat(MODE_FINISH, 24'h000000);
    send_beat(MODE_MAP, 24'h000000);
    send_beat(MODE_MAP, 24'h000002);
    send_beat(MODE_MAP, 24'hFFFFFF);
    send_beat(MODE_MAP, 24'hFF0000);
    send_beat(MODE_MAP, 24'h00FF00);
    send_beat(MODE_MAP, 24'h0000FF);
    send_beat(MODE_MAP, 24'h010101);
    send_beat(MODE_MAP, 24'h7F7F80);
    send_beat(MODE_MAP, 24'hAA5500);
    send_beat(MODE_CLEAR, 24'hFFFFFF);
    send_beat(MODE_FINISH, 24'hFFFFFF);
    send_beat(MODE_MAP, 24'hC86432);
    send_beat(MODE_MAP, 24'hFFFFFF);

    // The level table is now written, so any beat order is legal from here.
    while (beats_sent < TOTAL_BEATS) begin
      if ($urandom_range(0, 9) < 8) begin
        run_frame();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          noise_mode = mode_e'(2'($urandom_range(0, 3)));
          send_beat(noise_mode, random_pixel());
        end
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
